// File: hw/rtl/lp2c_pkg.sv
// Shared constants and types for the polar-to-Cartesian converter.
// No dependencies; every other file of the block imports this package.

package lp2c_pkg;

   // field widths
   localparam int unsigned ANGLE_W    = 16;
   localparam int unsigned OCT_A_W    = 14;                // octant angle 0..8192
   localparam int unsigned OUT_W      = 21;
   localparam int unsigned OUT_MAG_W  = OUT_W - 1;
   localparam logic [OUT_MAG_W-1:0] OUT_MAX = {OUT_MAG_W{1'b1}};

   // defaults for the top level parameters
   localparam int unsigned DIST_BITS_DEF      = 20;
   localparam int unsigned TRIG_FRAC_BITS_DEF = 16;

   // angle reduction
   localparam logic [OCT_A_W-1:0] OCTANT_SPAN  = 14'd8192;
   localparam logic [OCT_A_W:0]   QUARTER_SPAN = 15'd16384;

   // pi in Q32, radians per 2^-16 turn come out in Q30 after a shift of 17
   localparam int unsigned PI_W     = 34;
   localparam logic [PI_W-1:0] PI_Q32 = 34'd13493037705;
   localparam int unsigned XPROD_W  = OCT_A_W + PI_W;
   localparam int unsigned X_SHIFT  = 17;

   // Q30 series arithmetic
   localparam int unsigned Q_SHIFT      = 30;
   localparam int unsigned TERM_W       = 31;
   localparam int unsigned SUM_W        = 33;
   localparam logic [TERM_W-1:0] Q30_ONE = 31'h4000_0000;
   localparam int unsigned TAYLOR_TERMS = 6;

   // division by a small constant: reciprocal multiply plus one correction
   localparam int unsigned RECIP_W     = 32;
   localparam int unsigned RECIP_SHIFT = 32;
   localparam int unsigned R_W         = 9;               // remainder below 2 * 156

   typedef struct packed {
      logic [TERM_W-1:0]       x2;
      logic [TERM_W-1:0]       term_s;
      logic [TERM_W-1:0]       term_c;
      logic signed [SUM_W-1:0] sum_s;
      logic signed [SUM_W-1:0] sum_c;
   } trig_lane_type;

endpackage

// File: hw/rtl/lp2c_if.sv
// Valid/ready channel interfaces for the polar-to-Cartesian converter.
// Depends on lp2c_pkg for field widths.

interface lp2c_req_if
   import lp2c_pkg::*;
#(
   parameter int unsigned DIST_BITS = DIST_BITS_DEF
);
   logic                 valid;
   logic                 ready;
   logic [ANGLE_W-1:0]   angle_code;
   logic [DIST_BITS-1:0] distance_q2;

   modport source (output valid, output angle_code, output distance_q2, input ready);
   modport sink   (input valid, input angle_code, input distance_q2, output ready);
endinterface

interface lp2c_rsp_if
   import lp2c_pkg::*;
;
   logic                    valid;
   logic                    ready;
   logic signed [OUT_W-1:0] point_x;
   logic signed [OUT_W-1:0] point_y;

   modport source (output valid, output point_x, output point_y, input ready);
   modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

// File: hw/rtl/lp2c_taylor_step.sv
// One term of the sine and cosine Taylor series, as four pipeline stages:
// product, reciprocal multiply, remainder, correct and accumulate. Uses lp2c_pkg.

module lp2c_taylor_step
   import lp2c_pkg::*;
#(
   parameter int unsigned K      = 1,
   parameter int unsigned SIDE_W = 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_hold,
   input  trig_lane_type      in_lane,
   input  logic [SIDE_W-1:0]  in_side,
   output logic               out_valid,
   input  logic               out_hold,
   output trig_lane_type      out_lane,
   output logic [SIDE_W-1:0]  out_side
);

   localparam int unsigned DivS = (2 * K) * (2 * K + 1);
   localparam int unsigned DivC = (2 * K - 1) * (2 * K);
   localparam logic [63:0] RecipS = (64'd1 << RECIP_SHIFT) / DivS;
   localparam logic [63:0] RecipC = (64'd1 << RECIP_SHIFT) / DivC;
   localparam bit Subtract = (K % 2) == 1;
   localparam int unsigned PROD_W = 2 * TERM_W;
   localparam int unsigned RMUL_W = TERM_W + RECIP_W;

   logic                a_valid_ff, b_valid_ff, c_valid_ff, d_valid_ff;
   logic                hold_a, hold_b, hold_c, hold_d;
   trig_lane_type       a_lane_ff, b_lane_ff, c_lane_ff, d_lane_ff, d_lane_in;
   logic [SIDE_W-1:0]   a_side_ff, b_side_ff, c_side_ff, d_side_ff;
   logic [TERM_W-1:0]   a_ps_ff, a_pc_ff, a_ps_in, a_pc_in;
   logic [TERM_W-1:0]   b_ps_ff, b_pc_ff, b_qs_ff, b_qc_ff, b_qs_in, b_qc_in;
   logic [TERM_W-1:0]   c_qs_ff, c_qc_ff;
   logic [R_W-1:0]      c_rs_ff, c_rc_ff, c_rs_in, c_rc_in;
   logic [PROD_W-1:0]   prod_s, prod_c;
   logic [RMUL_W-1:0]   rmul_s, rmul_c;
   logic [TERM_W-1:0]   q_s, q_c;

   // a stage holds while it is full and the one after it cannot take its item
   assign hold_d  = d_valid_ff & out_hold;
   assign hold_c  = c_valid_ff & hold_d;
   assign hold_b  = b_valid_ff & hold_c;
   assign hold_a  = a_valid_ff & hold_b;
   assign in_hold = hold_a;

   // term times x squared, back to Q30
   always_comb begin
      prod_s  = PROD_W'(in_lane.term_s) * PROD_W'(in_lane.x2);
      prod_c  = PROD_W'(in_lane.term_c) * PROD_W'(in_lane.x2);
      a_ps_in = prod_s[TERM_W+Q_SHIFT-1:Q_SHIFT];
      a_pc_in = prod_c[TERM_W+Q_SHIFT-1:Q_SHIFT];
   end

   // quotient estimate, low by at most one
   always_comb begin
      rmul_s  = RMUL_W'(a_ps_ff) * RMUL_W'(RecipS[RECIP_W-1:0]);
      rmul_c  = RMUL_W'(a_pc_ff) * RMUL_W'(RecipC[RECIP_W-1:0]);
      b_qs_in = rmul_s[TERM_W+RECIP_SHIFT-1:RECIP_SHIFT];
      b_qc_in = rmul_c[TERM_W+RECIP_SHIFT-1:RECIP_SHIFT];
   end

   assign c_rs_in = R_W'(b_ps_ff - TERM_W'(b_qs_ff * TERM_W'(DivS)));
   assign c_rc_in = R_W'(b_pc_ff - TERM_W'(b_qc_ff * TERM_W'(DivC)));

   // fix the estimate, then fold the term into the running sums
   always_comb begin
      q_s = c_qs_ff + TERM_W'(c_rs_ff >= R_W'(DivS));
      q_c = c_qc_ff + TERM_W'(c_rc_ff >= R_W'(DivC));
      d_lane_in        = c_lane_ff;
      d_lane_in.term_s = q_s;
      d_lane_in.term_c = q_c;
      if (Subtract) begin
         d_lane_in.sum_s = c_lane_ff.sum_s - $signed({2'b00, q_s});
         d_lane_in.sum_c = c_lane_ff.sum_c - $signed({2'b00, q_c});
      end else begin
         d_lane_in.sum_s = c_lane_ff.sum_s + $signed({2'b00, q_s});
         d_lane_in.sum_c = c_lane_ff.sum_c + $signed({2'b00, q_c});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else begin
         if (!hold_a) a_valid_ff <= in_valid;
         if (!hold_b) b_valid_ff <= a_valid_ff;
         if (!hold_c) c_valid_ff <= b_valid_ff;
         if (!hold_d) d_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (!hold_a) begin
         a_lane_ff <= in_lane;
         a_side_ff <= in_side;
         a_ps_ff   <= a_ps_in;
         a_pc_ff   <= a_pc_in;
      end
      if (!hold_b) begin
         b_lane_ff <= a_lane_ff;
         b_side_ff <= a_side_ff;
         b_ps_ff   <= a_ps_ff;
         b_pc_ff   <= a_pc_ff;
         b_qs_ff   <= b_qs_in;
         b_qc_ff   <= b_qc_in;
      end
      if (!hold_c) begin
         c_lane_ff <= b_lane_ff;
         c_side_ff <= b_side_ff;
         c_qs_ff   <= b_qs_ff;
         c_qc_ff   <= b_qc_ff;
         c_rs_ff   <= c_rs_in;
         c_rc_ff   <= c_rc_in;
      end
      if (!hold_d) begin
         d_lane_ff <= d_lane_in;
         d_side_ff <= c_side_ff;
      end
   end

   assign out_valid = d_valid_ff;
   assign out_lane  = d_lane_ff;
   assign out_side  = d_side_ff;

endmodule

// File: hw/rtl/lidar_polar_to_cartesian.sv
// Polar-to-Cartesian converter for range-scanner samples: x = d*sin, y = d*cos.
// Depends on lp2c_pkg, lp2c_if and lp2c_taylor_step.
//
// Takes one sample per clock while no stall holds the input and offers its point
// through 30 register stages: three stages reduce the angle to an
// octant and form x and x squared in Q30, six series terms of four stages each
// build sine and cosine, and three stages round the trig values, scale by
// distance and saturate. Every stage moves on into a free slot on its own, so a
// stalled result leaves the earlier stages free to fill. Samples with zero
// distance are dropped at the input and yield no point.

module lidar_polar_to_cartesian
   import lp2c_pkg::*;
#(
   parameter int unsigned DIST_BITS      = DIST_BITS_DEF,
   parameter int unsigned TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   lp2c_req_if.sink   req_chan,
   lp2c_rsp_if.source rsp_chan
);

   localparam int unsigned TRIG_W = TRIG_FRAC_BITS + 1;
   localparam int unsigned SIDE_W = 3 + DIST_BITS;
   localparam int unsigned MUL_W  = DIST_BITS + TRIG_W;
   localparam int unsigned PROD_W = DIST_BITS + 1;
   localparam int unsigned CMP_W  = (PROD_W > OUT_MAG_W) ? PROD_W : OUT_MAG_W;
   localparam int unsigned SQ_W   = 2 * TERM_W;

   // input stage
   logic                  v0_ff, h0;
   logic [ANGLE_W-1:0]    angle_ff;
   logic [DIST_BITS-1:0]  dist0_ff;

   // angle reduction and x
   logic                  v1_ff, h1;
   logic [OCT_A_W-1:0]    oct_r, oct_a;
   logic                  swap_in;
   logic [XPROD_W-1:0]    xprod;
   logic [TERM_W-1:0]     x1_ff;
   logic [SIDE_W-1:0]     side1_ff, side1_in;

   // x squared
   logic                  v2_ff, h2;
   logic [SQ_W-1:0]       sq;
   logic [TERM_W-1:0]     x2_in, x2_ff;
   logic [TERM_W-1:0]     x_s2_ff;
   logic [SIDE_W-1:0]     side2_ff;

   // series chain
   logic                  step_valid [TAYLOR_TERMS+1];
   logic                  step_hold  [TAYLOR_TERMS+1];
   trig_lane_type         step_lane  [TAYLOR_TERMS+1];
   logic [SIDE_W-1:0]     step_side  [TAYLOR_TERMS+1];

   // trig rounding and quadrant mapping
   logic                  vt_ff, ht;
   logic [TRIG_W-1:0]     sin_t, cos_t, s0, c0;
   logic [TRIG_W-1:0]     mag_x_ff, mag_y_ff;
   logic                  neg_x_ff, neg_y_ff;
   logic [DIST_BITS-1:0]  dist_t_ff;
   logic [1:0]            quad_e;
   logic                  swap_e;
   logic [DIST_BITS-1:0]  dist_e;

   // scaling
   logic                  vm_ff, hm;
   logic [MUL_W-1:0]      mul_x, mul_y;
   logic [PROD_W-1:0]     prod_x_ff, prod_y_ff;
   logic                  neg_xm_ff, neg_ym_ff;

   // output register
   logic                  vo_ff, ho;
   logic [CMP_W-1:0]      ext_x, ext_y;
   logic [OUT_MAG_W-1:0]  sat_x, sat_y;
   logic signed [OUT_W-1:0] point_x_ff, point_y_ff, point_x_in, point_y_in;

   function automatic logic [TRIG_W-1:0] to_trig(input logic signed [SUM_W-1:0] v);
      logic [SUM_W-1:0] clamped;
      logic [SUM_W-1:0] rounded;
      clamped = v[SUM_W-1] ? '0 : SUM_W'(v);
      rounded = clamped + (SUM_W'(1) << (Q_SHIFT - 1 - TRIG_FRAC_BITS));
      return TRIG_W'(rounded >> (Q_SHIFT - TRIG_FRAC_BITS));
   endfunction

   // hold chain, from the output back to the input
   assign ho = vo_ff & ~rsp_chan.ready;
   assign hm = vm_ff & ho;
   assign ht = vt_ff & hm;
   assign step_hold[TAYLOR_TERMS] = ht;
   assign h2 = v2_ff & step_hold[0];
   assign h1 = v1_ff & h2;
   assign h0 = v0_ff & h1;
   assign req_chan.ready = ~h0;

   // fold the quadrant into an octant angle 0..8192
   always_comb begin
      oct_r   = angle_ff[OCT_A_W-1:0];
      swap_in = oct_r > OCTANT_SPAN;
      oct_a   = swap_in ? OCT_A_W'(QUARTER_SPAN - {1'b0, oct_r}) : oct_r;
      xprod   = XPROD_W'(oct_a) * XPROD_W'(PI_Q32) + (XPROD_W'(1) << (X_SHIFT - 1));
      side1_in = {angle_ff[ANGLE_W-1 -: 2], swap_in, dist0_ff};
   end

   always_comb begin
      sq    = SQ_W'(x1_ff) * SQ_W'(x1_ff) + (SQ_W'(1) << (Q_SHIFT - 1));
      x2_in = sq[TERM_W+Q_SHIFT-1:Q_SHIFT];
   end

   assign step_valid[0]       = v2_ff;
   assign step_side[0]        = side2_ff;
   assign step_lane[0].x2     = x2_ff;
   assign step_lane[0].term_s = x_s2_ff;
   assign step_lane[0].term_c = Q30_ONE;
   assign step_lane[0].sum_s  = $signed({2'b00, x_s2_ff});
   assign step_lane[0].sum_c  = $signed({2'b00, Q30_ONE});

   for (genvar k = 0; k < TAYLOR_TERMS; k++) begin : g_term
      lp2c_taylor_step #(
         .K      (k + 1),
         .SIDE_W (SIDE_W)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (step_valid[k]),
         .in_hold   (step_hold[k]),
         .in_lane   (step_lane[k]),
         .in_side   (step_side[k]),
         .out_valid (step_valid[k+1]),
         .out_hold  (step_hold[k+1]),
         .out_lane  (step_lane[k+1]),
         .out_side  (step_side[k+1])
      );
   end

   // round to the trig format, undo the octant swap, apply the quadrant
   always_comb begin
      {quad_e, swap_e, dist_e} = step_side[TAYLOR_TERMS];
      sin_t = to_trig(step_lane[TAYLOR_TERMS].sum_s);
      cos_t = to_trig(step_lane[TAYLOR_TERMS].sum_c);
      s0    = swap_e ? cos_t : sin_t;
      c0    = swap_e ? sin_t : cos_t;
   end

   always_comb begin
      mul_x = MUL_W'(dist_t_ff) * MUL_W'(mag_x_ff) + (MUL_W'(1) << (TRIG_FRAC_BITS - 1));
      mul_y = MUL_W'(dist_t_ff) * MUL_W'(mag_y_ff) + (MUL_W'(1) << (TRIG_FRAC_BITS - 1));
   end

   always_comb begin
      ext_x = CMP_W'(prod_x_ff);
      ext_y = CMP_W'(prod_y_ff);
      sat_x = (ext_x > CMP_W'(OUT_MAX)) ? OUT_MAX : OUT_MAG_W'(ext_x);
      sat_y = (ext_y > CMP_W'(OUT_MAX)) ? OUT_MAX : OUT_MAG_W'(ext_y);
      point_x_in = neg_xm_ff ? -$signed({1'b0, sat_x}) : $signed({1'b0, sat_x});
      point_y_in = neg_ym_ff ? -$signed({1'b0, sat_y}) : $signed({1'b0, sat_y});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         vt_ff <= 1'b0;
         vm_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         // drop zero-distance samples here
         if (!h0) v0_ff <= req_chan.valid & (req_chan.distance_q2 != '0);
         if (!h1) v1_ff <= v0_ff;
         if (!h2) v2_ff <= v1_ff;
         if (!ht) vt_ff <= step_valid[TAYLOR_TERMS];
         if (!hm) vm_ff <= vt_ff;
         if (!ho) vo_ff <= vm_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (!h0) begin
         angle_ff <= req_chan.angle_code;
         dist0_ff <= req_chan.distance_q2;
      end
      if (!h1) begin
         x1_ff    <= xprod[TERM_W+X_SHIFT-1:X_SHIFT];
         side1_ff <= side1_in;
      end
      if (!h2) begin
         x_s2_ff  <= x1_ff;
         x2_ff    <= x2_in;
         side2_ff <= side1_ff;
      end
      if (!ht) begin
         mag_x_ff  <= quad_e[0] ? c0 : s0;
         mag_y_ff  <= quad_e[0] ? s0 : c0;
         neg_x_ff  <= quad_e[1];
         neg_y_ff  <= quad_e[1] ^ quad_e[0];
         dist_t_ff <= dist_e;
      end
      if (!hm) begin
         prod_x_ff <= mul_x[TRIG_FRAC_BITS +: PROD_W];
         prod_y_ff <= mul_y[TRIG_FRAC_BITS +: PROD_W];
         neg_xm_ff <= neg_x_ff;
         neg_ym_ff <= neg_y_ff;
      end
      if (!ho) begin
         point_x_ff <= point_x_in;
         point_y_ff <= point_y_in;
      end
   end

   assign rsp_chan.valid   = vo_ff;
   assign rsp_chan.point_x = point_x_ff;
   assign rsp_chan.point_y = point_y_ff;

endmodule

// File: hw/rtl/lp2c_checker.sv
// Port-level checks for lidar_polar_to_cartesian, bound to the top level.
// Depends on lp2c_pkg for the output width.

module lp2c_checker
   import lp2c_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic signed [OUT_W-1:0] point_x,
   input logic signed [OUT_W-1:0] point_y
);

   localparam logic signed [OUT_W-1:0] MostNeg = {1'b1, {(OUT_W-1){1'b0}}};

   // reset empties the pipeline: nothing to show, room for a transfer
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid && req_ready)
      else $error("pipeline not empty after reset");

   // a stalled result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(point_x) && $stable(point_y))
      else $error("result changed while stalled");

   // saturation keeps magnitudes symmetric
   a_mag_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> point_x != MostNeg && point_y != MostNeg)
      else $error("coordinate outside saturation range");

   // a free output register never blocks the input side
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input blocked with empty output");

endmodule

bind lidar_polar_to_cartesian lp2c_checker u_lp2c_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .point_x   (rsp_chan.point_x),
   .point_y   (rsp_chan.point_y)
);

// File: bench/lp2c_point_checker.sv
`timescale 1ns / 1ps
// Checker for the polar-to-Cartesian converter: watches both channels, predicts
// each point from the accepted sample and compares it with the delivered one.
// Depends on lp2c_pkg and the channel interfaces in lp2c_if.

module lp2c_point_checker
   import lp2c_pkg::*;
#(
   parameter int unsigned DIST_BITS      = DIST_BITS_DEF,
   parameter int unsigned TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF
) (
   input  logic  clock,
   input  logic  reset,
   lp2c_req_if   req_chan,
   lp2c_rsp_if   rsp_chan,
   output int    fail_count,
   output int    points_pending
);

   typedef enum logic [1:0] {QUAD_NE, QUAD_SE, QUAD_SW, QUAD_NW} quadrant_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] x;
      logic signed [OUT_W-1:0] y;
   } point_type;

   point_type expected_points[$];

   // Q30 Taylor series over one octant, rounded to nearest at TRIG_FRAC_BITS
   function automatic void octant_sin_cos(input logic [OCT_A_W-1:0] a,
                                          output longint sin_q, output longint cos_q);
      longint unsigned rad, rad_sq, term_s, term_c, k;
      longint sum_s, sum_c;
      rad    = (64'(a) * 64'(PI_Q32) + (64'd1 << 16)) >> X_SHIFT;
      rad_sq = (rad * rad + (64'd1 << 29)) >> Q_SHIFT;
      term_s = rad;
      term_c = 64'd1 << Q_SHIFT;
      sum_s  = longint'(rad);
      sum_c  = longint'(term_c);
      for (k = 1; k <= TAYLOR_TERMS; k++) begin
         term_s = ((term_s * rad_sq) >> Q_SHIFT) / ((2 * k) * (2 * k + 1));
         term_c = ((term_c * rad_sq) >> Q_SHIFT) / ((2 * k - 1) * (2 * k));
         if (k[0]) begin
            sum_s = sum_s - longint'(term_s);
            sum_c = sum_c - longint'(term_c);
         end else begin
            sum_s = sum_s + longint'(term_s);
            sum_c = sum_c + longint'(term_c);
         end
      end
      if (sum_s < 0) sum_s = 0;
      if (sum_c < 0) sum_c = 0;
      sin_q = longint'((longint'(sum_s) + (64'd1 << (29 - TRIG_FRAC_BITS)))
                       >> (Q_SHIFT - TRIG_FRAC_BITS));
      cos_q = longint'((longint'(sum_c) + (64'd1 << (29 - TRIG_FRAC_BITS)))
                       >> (Q_SHIFT - TRIG_FRAC_BITS));
   endfunction

   // round magnitude half away from zero, clamp, then restore sign
   function automatic logic [OUT_W-1:0] scale_coord(input longint unsigned range_q2,
                                                    input longint trig);
      logic neg;
      longint unsigned mag, prod;
      neg  = trig < 0;
      mag  = neg ? longint'(-trig) : longint'(trig);
      prod = (range_q2 * mag + (64'd1 << (TRIG_FRAC_BITS - 1))) >> TRIG_FRAC_BITS;
      if (prod > 64'(OUT_MAX)) prod = 64'(OUT_MAX);
      return neg ? OUT_W'(-prod) : OUT_W'(prod);
   endfunction

   function automatic point_type predict_point(input logic [ANGLE_W-1:0] angle,
                                               input logic [DIST_BITS-1:0] range_q2);
      quadrant_type quad;
      logic [OCT_A_W-1:0] rem;
      longint s0, c0, s, c;
      point_type pt;
      quad = quadrant_type'(angle[ANGLE_W-1 -: 2]);
      rem  = angle[OCT_A_W-1:0];
      if (rem <= OCTANT_SPAN) octant_sin_cos(rem, s0, c0);
      else                    octant_sin_cos(OCT_A_W'(QUARTER_SPAN - rem), c0, s0);
      case (quad)
         QUAD_NE: begin s = s0;  c = c0;  end
         QUAD_SE: begin s = c0;  c = -s0; end
         QUAD_SW: begin s = -s0; c = -c0; end
         default: begin s = -c0; c = s0;  end
      endcase
      pt.x = scale_coord(64'(range_q2), s);
      pt.y = scale_coord(64'(range_q2), c);
      return pt;
   endfunction

   always @(posedge clock) begin : watch
      point_type want;
      if (reset) begin
         expected_points.delete();
      end else begin
         // zero distance means no return: nothing to expect
         if (req_chan.valid && req_chan.ready && req_chan.distance_q2 != '0)
            expected_points.push_back(predict_point(req_chan.angle_code,
                                                    req_chan.distance_q2));
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_points.size() == 0) begin
               $error("point transfer with none expected: x=%0d y=%0d",
                      rsp_chan.point_x, rsp_chan.point_y);
               fail_count = fail_count + 1;
            end else begin
               want = expected_points.pop_front();
               if (rsp_chan.point_x !== want.x) begin
                  $error("point_x: expected %0d, got %0d", want.x, rsp_chan.point_x);
                  fail_count = fail_count + 1;
               end
               if (rsp_chan.point_y !== want.y) begin
                  $error("point_y: expected %0d, got %0d", want.y, rsp_chan.point_y);
                  fail_count = fail_count + 1;
               end
            end
         end
      end
      points_pending = expected_points.size();
   end

endmodule

// File: bench/tb_lidar_polar_to_cartesian.sv
`timescale 1ns / 1ps
// Top of the polar-to-Cartesian converter bench: clock, reset, sample and
// backpressure stimulus, verdict. Depends on lp2c_pkg, lp2c_if and lp2c_point_checker.

module tb_lidar_polar_to_cartesian;
   import lp2c_pkg::*;

   localparam int unsigned DIST_BITS      = DIST_BITS_DEF;
   localparam int unsigned TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF;
   localparam int          HOLD_CYCLES    = 300;
   localparam int          SETTLE_CYCLES  = 60;
   localparam int          CYCLE_LIMIT    = 200000;
   localparam int          DIRECTED_N     = 25;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   points_pending;
   int   cycle_count = 0;
   bit   tx_idle_on = 1'b1;
   bit   rx_idle_on = 1'b1;
   bit   hold_req   = 1'b0;
   bit   hold_done  = 1'b0;

   lp2c_req_if #(.DIST_BITS(DIST_BITS)) req_chan ();
   lp2c_rsp_if rsp_chan ();

   lidar_polar_to_cartesian #(
      .DIST_BITS      (DIST_BITS),
      .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   lp2c_point_checker #(
      .DIST_BITS      (DIST_BITS),
      .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
   ) point_check (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .fail_count     (fail_count),
      .points_pending (points_pending)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // axes, octant edges, full scale, zero and tiny distances
   logic [ANGLE_W-1:0]   dir_angle [DIRECTED_N] = '{
      16'd0, 16'd16384, 16'd32768, 16'd49152, 16'd8192, 16'd24576, 16'd40960,
      16'd57344, 16'd65535, 16'd8191, 16'd8193, 16'd16383, 16'd1, 16'd100,
      16'd8192, 16'd0, 16'd12345, 16'd65535, 16'd32767, 16'd16385, 16'd43690,
      16'd21845, 16'd4096, 16'd61440, 16'd0};
   logic [DIST_BITS-1:0] dir_dist [DIRECTED_N] = '{
      20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF,
      20'hFFFFF, 20'hFFFFF, 20'd777777, 20'd777777, 20'd524288, 20'd1, 20'd1,
      20'd1, 20'd0, 20'd0, 20'd0, 20'd3, 20'd2, 20'd699050,
      20'd349525, 20'd65535, 20'd1, 20'd1};

   // offer one sample and hold it until the transfer
   task automatic send_sample(input logic [ANGLE_W-1:0] angle,
                              input logic [DIST_BITS-1:0] range_q2);
      @(negedge clock);
      while (tx_idle_on && $urandom_range(99) < 15) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.angle_code  <= angle;
      req_chan.distance_q2 <= range_q2;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic send_random(input int count);
      int sel;
      logic [DIST_BITS-1:0] range_q2;
      repeat (count) begin
         sel = $urandom_range(99);
         if (sel < 5)       range_q2 = '0;
         else if (sel < 20) range_q2 = DIST_BITS'($urandom_range(1, 15));
         else if (sel < 25) range_q2 = '1;
         else               range_q2 = DIST_BITS'($urandom_range(1, (1 << DIST_BITS) - 1));
         send_sample(ANGLE_W'($urandom_range(0, 65535)), range_q2);
      end
   endtask

   task automatic drop_valid();
      @(negedge clock);
      req_chan.valid <= 1'b0;
   endtask

   initial begin : rsp_drive
      rsp_chan.ready <= 1'b0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (hold_req && !hold_done) begin
            // stall the result side so the pipeline backs up into the input
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_done = 1'b1;
         end else begin
            rsp_chan.ready <= !rx_idle_on || ($urandom_range(99) >= 15);
         end
      end
   end

   initial begin : stimulus
      req_chan.valid       <= 1'b0;
      req_chan.angle_code  <= '0;
      req_chan.distance_q2 <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_N; i++) send_sample(dir_angle[i], dir_dist[i]);
      send_random(300);

      // full rate on both sides
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      send_random(200);
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;

      // keep offering through a long result stall
      hold_req = 1'b1;
      send_random(150);
      drop_valid();
      wait (hold_done);

      // pause until the pipeline is empty
      wait (points_pending == 0);
      send_random(300);

      drop_valid();
      wait (points_pending == 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
